>>> rtl/ccs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccs_pkg: shared definitions for the chunk counting sort
// Sizes, field widths and the command and status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package ccs_pkg;

  localparam int ALPHABET    = 256;
  localparam int SYM_W       = $clog2(ALPHABET);
  localparam int CHUNK_DEPTH = 64;
  localparam int IDX_W       = $clog2(CHUNK_DEPTH);
  localparam int FILL_W      = IDX_W + 1;
  localparam int CNT_W       = ((SYM_W > IDX_W) ? SYM_W : IDX_W) + 1;

  localparam int SYMBOL_W    = 8;
  localparam int CFG_W       = 7;
  localparam int TDATA_OUT_W = 8;

  localparam logic [CFG_W-1:0] CHUNK_SIZE_RESET = CFG_W'(64);

  typedef struct packed {
    logic load_acc;
    logic inc_wr;
    logic pfx_start;
    logic pfx_step;
    logic sc_sym_rd;
    logic sc_bkt_rd;
    logic sc_wr;
    logic em_rd;
    logic em_ld;
    logic cnt_clr;
    logic cnt_inc;
    logic chunk_done;
  } ccs_cmd_t;

  typedef struct packed {
    logic close;
    logic pfx_done;
    logic idx_last;
    logic out_free;
  } ccs_stat_t;

endpackage
`default_nettype wire

>>> rtl/chunk_counting_sort_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chunk_counting_sort_top: stable counting sort of symbols in chunks
// Symbols arrive one per transfer; on chunk close the positions within the
// chunk are streamed out in stable sorted order, the final one with tlast.
// ----------------------------------------------------------------------------
// A chunk closes on a symbol with tlast set or when chunk_size symbols have
// been taken (zero acts as one, values above 64 act as 64). Each symbol is
// loaded by a read-modify-write of the histogram RAM, and the next symbol is
// not accepted until the increment is written. On close the block stops
// accepting and runs a prefix sweep over the 256 histogram entries, a stable
// scatter over the symbols, then after a read of the first position emits one
// position per cycle while the sink is ready. The histogram is cleared at once
// through per-entry flags, so there is no clearing pass after reset or between
// chunks. The next chunk may load while the final position still waits in the
// output register.
// ----------------------------------------------------------------------------
module chunk_counting_sort_top import ccs_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_W-1:0]       cfg_wdata_i,    // chunk_size
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [SYMBOL_W-1:0]    s_axis_tdata_i, // [7:0] symbol
  input  wire logic                   s_axis_tlast_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [TDATA_OUT_W-1:0]      m_axis_tdata_o, // [5:0] position, [7:6] zero
  output logic                        m_axis_tlast_o
);

  ccs_cmd_t  cmd;
  ccs_stat_t stat;

  ccs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ccs_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .symbol_i       (s_axis_tdata_i),
    .end_of_chunk_i (s_axis_tlast_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .m_tready_i     (m_axis_tready_i),
    .m_tvalid_o     (m_axis_tvalid_o),
    .m_tdata_o      (m_axis_tdata_o),
    .m_tlast_o      (m_axis_tlast_o)
  );

endmodule
`default_nettype wire

>>> rtl/ccs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccs_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ccs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/ccs_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccs_dp: chunk counting sort datapath
// Histogram, symbol and sorted-position memories, counters, prefix sum
// accumulator and the output register.
// ----------------------------------------------------------------------------
module ccs_dp import ccs_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_W-1:0]       cfg_wdata_i,
  input  wire logic [SYMBOL_W-1:0]    symbol_i,
  input  wire logic                   end_of_chunk_i,
  input  wire ccs_cmd_t               cmd_i,
  output ccs_stat_t                   stat_o,
  input  wire logic                   m_tready_i,
  output logic                        m_tvalid_o,
  output logic [TDATA_OUT_W-1:0]      m_tdata_o,
  output logic                        m_tlast_o
);

  logic [CFG_W-1:0]    chunk_size_q;
  logic [FILL_W-1:0]   fill_q, fill_d, limit, fill_inc;
  logic [SYM_W-1:0]    sym_q, in_sym;
  logic                close_q, close_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d, cnt_nx, cnt_m1;
  logic [FILL_W-1:0]   sum_q, sum_d;
  logic                out_valid_q;
  logic [IDX_W-1:0]    out_pos_q;
  logic                out_last_q;
  logic [ALPHABET-1:0] vld_q, vld_d;
  logic                vld_rd_q;
  logic                pfx_done, pfx_wr, idx_last;

  logic                b_re, b_we;
  logic [SYM_W-1:0]    b_raddr, b_waddr;
  logic [FILL_W-1:0]   b_rdata, b_wdata, bkt_val, bkt_inc;

  logic                s_re;
  logic [IDX_W-1:0]    s_raddr;
  logic [SYM_W-1:0]    s_rdata;

  logic                o_re;
  logic [IDX_W-1:0]    o_raddr;
  logic [IDX_W-1:0]    o_rdata;

  assign in_sym   = symbol_i[SYM_W-1:0];
  assign cnt_nx   = cnt_q + CNT_W'(1);
  assign cnt_m1   = cnt_q - CNT_W'(1);
  assign fill_inc = fill_q + FILL_W'(1);
  assign pfx_done = (cnt_q == CNT_W'(ALPHABET));
  assign pfx_wr   = cmd_i.pfx_step && (cnt_q != '0);
  assign idx_last = (cnt_nx == CNT_W'(fill_q));
  assign bkt_val  = vld_rd_q ? b_rdata : '0;
  assign bkt_inc  = bkt_val + FILL_W'(1);

  // chunk limit: zero acts as one, large values saturate
  always_comb begin
    if (chunk_size_q == '0) begin
      limit = FILL_W'(1);
    end else if (FILL_W'(chunk_size_q) > FILL_W'(CHUNK_DEPTH)) begin
      limit = FILL_W'(CHUNK_DEPTH);
    end else begin
      limit = FILL_W'(chunk_size_q);
    end
  end

  assign close_d = end_of_chunk_i || (fill_inc >= limit);

  // histogram port selection
  always_comb begin
    b_re    = 1'b0;
    b_raddr = in_sym;
    if (cmd_i.load_acc) begin
      b_re    = 1'b1;
      b_raddr = in_sym;
    end else if (cmd_i.pfx_step && !pfx_done) begin
      b_re    = 1'b1;
      b_raddr = cnt_q[SYM_W-1:0];
    end else if (cmd_i.sc_bkt_rd) begin
      b_re    = 1'b1;
      b_raddr = s_rdata;
    end
  end

  always_comb begin
    b_we    = 1'b0;
    b_waddr = sym_q;
    b_wdata = bkt_inc;
    if (cmd_i.inc_wr) begin
      b_we    = 1'b1;
    end else if (pfx_wr) begin
      b_we    = 1'b1;
      b_waddr = cnt_m1[SYM_W-1:0];
      b_wdata = sum_q;
    end else if (cmd_i.sc_wr) begin
      b_we    = 1'b1;
      b_waddr = s_rdata;
    end
  end

  // entries without a flag read as zero, so the histogram clears at once
  always_comb begin
    vld_d = vld_q;
    if (cmd_i.chunk_done) begin
      vld_d = '0;
    end else if (b_we) begin
      vld_d[b_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (b_re) begin
        vld_rd_q <= vld_q[b_raddr];
      end
    end
  end

  ccs_ram #(.WIDTH(FILL_W), .DEPTH(ALPHABET)) u_bucket_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .re_i    (b_re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // symbol store, next symbol fetched during each scatter write
  assign s_re    = cmd_i.sc_sym_rd || cmd_i.sc_wr;
  assign s_raddr = cmd_i.sc_wr ? cnt_nx[IDX_W-1:0] : cnt_q[IDX_W-1:0];

  ccs_ram #(.WIDTH(SYM_W), .DEPTH(CHUNK_DEPTH)) u_symbol_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_acc),
    .waddr_i (fill_q[IDX_W-1:0]),
    .wdata_i (in_sym),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  assign o_re    = cmd_i.em_rd || cmd_i.em_ld;
  assign o_raddr = cmd_i.em_ld ? cnt_nx[IDX_W-1:0] : cnt_q[IDX_W-1:0];

  ccs_ram #(.WIDTH(IDX_W), .DEPTH(CHUNK_DEPTH)) u_sorted_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.sc_wr),
    .waddr_i (bkt_val[IDX_W-1:0]),
    .wdata_i (cnt_q[IDX_W-1:0]),
    .re_i    (o_re),
    .raddr_i (o_raddr),
    .rdata_o (o_rdata)
  );

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.chunk_done) begin
      fill_d = '0;
    end else if (cmd_i.load_acc) begin
      fill_d = fill_inc;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.pfx_start || cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_nx;
    end
  end

  always_comb begin
    sum_d = sum_q;
    if (cmd_i.pfx_start) begin
      sum_d = '0;
    end else if (pfx_wr) begin
      sum_d = sum_q + bkt_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_size_q <= CHUNK_SIZE_RESET;
      fill_q       <= '0;
      close_q      <= 1'b0;
      cnt_q        <= '0;
      sum_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        chunk_size_q <= cfg_wdata_i;
      end
      fill_q <= fill_d;
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      if (cmd_i.load_acc) begin
        close_q <= close_d;
      end
      if (cmd_i.em_ld) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_acc) begin
      sym_q <= in_sym;
    end
    if (cmd_i.em_ld) begin
      out_pos_q  <= o_rdata;
      out_last_q <= idx_last;
    end
  end

  assign stat_o.close    = close_q;
  assign stat_o.pfx_done = pfx_done;
  assign stat_o.idx_last = idx_last;
  assign stat_o.out_free = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = TDATA_OUT_W'(out_pos_q);
  assign m_tlast_o  = out_last_q;

  // a chunk never grows past the store
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_acc |-> (fill_q < FILL_W'(CHUNK_DEPTH)))
    else $error("symbol taken into a full chunk");

  // running bucket start stays within the chunk
  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pfx_step |-> (sum_q <= fill_q))
    else $error("prefix sum exceeds chunk fill");

  // scatter destination lies inside the chunk
  a_dst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sc_wr |-> (bkt_val < fill_q))
    else $error("scatter destination outside chunk");

endmodule
`default_nettype wire

>>> rtl/ccs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccs_ctrl: chunk counting sort controller
// Sequences load, histogram update, prefix sweep, scatter and emission.
// ----------------------------------------------------------------------------
module ccs_ctrl import ccs_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      s_tvalid_i,
  output logic           s_tready_o,
  input  wire ccs_stat_t stat_i,
  output ccs_cmd_t       cmd_o
);

  typedef enum logic [7:0] {
    S_LOAD  = 8'b0000_0001,
    S_INC   = 8'b0000_0010,
    S_PFX   = 8'b0000_0100,
    S_SCSYM = 8'b0000_1000,
    S_SCBKT = 8'b0001_0000,
    S_SCWR  = 8'b0010_0000,
    S_EMRD  = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load_acc = 1'b1;
          state_d        = S_INC;
        end
      end
      S_INC: begin
        cmd_o.inc_wr = 1'b1;
        if (stat_i.close) begin
          cmd_o.pfx_start = 1'b1;
          state_d         = S_PFX;
        end else begin
          state_d = S_LOAD;
        end
      end
      S_PFX: begin
        cmd_o.pfx_step = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        if (stat_i.pfx_done) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_SCSYM;
        end
      end
      S_SCSYM: begin
        cmd_o.sc_sym_rd = 1'b1;
        state_d         = S_SCBKT;
      end
      S_SCBKT: begin
        cmd_o.sc_bkt_rd = 1'b1;
        state_d         = S_SCWR;
      end
      S_SCWR: begin
        cmd_o.sc_wr = 1'b1;
        if (stat_i.idx_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_EMRD;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_SCBKT;
        end
      end
      S_EMRD: begin
        cmd_o.em_rd = 1'b1;
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.em_ld   = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          if (stat_i.idx_last) begin
            cmd_o.chunk_done = 1'b1;
            state_d          = S_LOAD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the chunk counting sort
// Streams symbols into the block, sorts each closed chunk stably in a local
// model and compares every emitted position and tlast against it, under
// random source and sink idling, a long sink hold-off and chunk size changes.
// ----------------------------------------------------------------------------
module tb;
  import ccs_pkg::*;

  localparam int IDLE_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 600;
  localparam int RANDOM_ITEMS  = 290;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [IDX_W-1:0] position;
    logic             last;
  } sorted_pos_t;

  class chunk_sort_checker;
    logic [CFG_W-1:0]    chunk_size;
    logic [SYMBOL_W-1:0] chunk_syms[$];
    sorted_pos_t         sorted_positions_q[$];
    int                  mismatches;

    function new();
      chunk_size = CHUNK_SIZE_RESET;
      mismatches = 0;
    endfunction

    function void set_chunk_size(logic [CFG_W-1:0] value);
      chunk_size = value;
    endfunction

    function int pending();
      return sorted_positions_q.size();
    endfunction

    function void sort_chunk();
      int unsigned bucket_start[ALPHABET];
      int unsigned sorted_idx[CHUNK_DEPTH];
      int unsigned sum;
      int unsigned cnt;
      int unsigned n;
      sorted_pos_t entry;
      n = chunk_syms.size();
      for (int s = 0; s < ALPHABET; s++) bucket_start[s] = 0;
      foreach (chunk_syms[k]) bucket_start[chunk_syms[k] % ALPHABET]++;
      sum = 0;
      // exclusive prefix sum turns counts into bucket starts
      for (int s = 0; s < ALPHABET; s++) begin
        cnt = bucket_start[s];
        bucket_start[s] = sum;
        sum += cnt;
      end
      for (int k = 0; k < n; k++) begin
        sorted_idx[bucket_start[chunk_syms[k] % ALPHABET]] = k;
        bucket_start[chunk_syms[k] % ALPHABET]++;
      end
      for (int k = 0; k < n; k++) begin
        entry.position = IDX_W'(sorted_idx[k]);
        entry.last     = (k == n - 1);
        sorted_positions_q.push_back(entry);
      end
      chunk_syms.delete();
    endfunction

    function void note_symbol(logic [SYMBOL_W-1:0] sym, logic eoc);
      int unsigned limit;
      limit = chunk_size;
      if (limit == 0) limit = 1;
      if (limit > CHUNK_DEPTH) limit = CHUNK_DEPTH;
      if (chunk_syms.size() < CHUNK_DEPTH) chunk_syms.push_back(sym);
      if (eoc || chunk_syms.size() >= limit) sort_chunk();
    endfunction

    function void check_position(logic [TDATA_OUT_W-1:0] tdata, logic tlast);
      sorted_pos_t want;
      if (sorted_positions_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected position %0d last %0b", $time, tdata, tlast);
      end else begin
        want = sorted_positions_q.pop_front();
        if (tdata !== TDATA_OUT_W'(want.position) || tlast !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: position mismatch: expected %0d last %0b, got %0d last %0b",
                     $time, want.position, want.last, tdata, tlast);
        end
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_W-1:0]       cfg_wdata_i;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [SYMBOL_W-1:0]    s_axis_tdata_i;
  logic                   s_axis_tlast_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [TDATA_OUT_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tlast_o;

  chunk_sort_checker chk;
  bit src_burst;
  bit snk_burst;
  int sink_hold;
  int stall_cycles;

  chunk_counting_sort_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [SYMBOL_W-1:0] pick_symbol();
    case ($urandom_range(0, 3))
      0: return SYMBOL_W'($urandom_range(0, 3));
      1: return SYMBOL_W'($urandom_range(252, 255));
      default: return SYMBOL_W'($urandom_range(0, 255));
    endcase
  endfunction

  // entered and left at a falling edge
  task automatic send_symbol(input logic [SYMBOL_W-1:0] sym, input logic eoc);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= sym;
    s_axis_tlast_i  <= eoc;
    do @(posedge clk_i); while (!s_axis_tready_o);
    chk.note_symbol(sym, eoc);
    @(negedge clk_i);
  endtask

  task automatic take_position(input int gap);
    if (gap > 0) begin
      m_axis_tready_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    m_axis_tready_i <= 1'b1;
    do @(posedge clk_i); while (!m_axis_tvalid_o);
    chk.check_position(m_axis_tdata_o, m_axis_tlast_o);
    @(negedge clk_i);
  endtask

  // only once every sorted position has left the block
  task automatic write_chunk_size(input logic [CFG_W-1:0] value);
    s_axis_tvalid_i <= 1'b0;
    while (chk.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    chk.set_chunk_size(value);
  endtask

  initial begin
    int gap;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      gap = snk_burst ? 0 : $urandom_range(0, 14);
      if (sink_hold > 0) begin
        gap = sink_hold;
        sink_hold = 0;
      end
      take_position(gap);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int items;
    int phase;
    int n;
    int eoc_odds;
    logic [CFG_W-1:0] size;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    src_burst       = 1'b0;
    snk_burst       = 1'b0;
    sink_hold       = 0;
    stall_cycles    = 0;
    chk = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // extremes and equal symbols keeping arrival order
    send_symbol(8'hff, 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hff, 1'b1);
    send_symbol(8'h80, 1'b0);
    send_symbol(8'h7f, 1'b0);
    send_symbol(8'h01, 1'b0);
    send_symbol(8'hfe, 1'b0);
    send_symbol(8'h80, 1'b1);
    // zero size acts as one
    write_chunk_size(CFG_W'(0));
    send_symbol(8'haa, 1'b0);
    send_symbol(8'h55, 1'b1);
    // close on size, then both closing conditions together
    write_chunk_size(CFG_W'(3));
    send_symbol(8'h10, 1'b0);
    send_symbol(8'h03, 1'b0);
    send_symbol(8'h10, 1'b0);
    send_symbol(8'h02, 1'b0);
    send_symbol(8'h02, 1'b0);
    send_symbol(8'h01, 1'b1);
    // size lowered under a partly filled chunk
    write_chunk_size(CFG_W'(64));
    for (int i = 0; i < 5; i++) send_symbol(pick_symbol(), 1'b0);
    write_chunk_size(CFG_W'(2));
    send_symbol(pick_symbol(), 1'b0);

    items = 0;
    phase = 0;
    while (items < RANDOM_ITEMS) begin
      n = $urandom_range(10, 40);
      case (phase)
        0: begin size = CFG_W'(127); eoc_odds = 0; n = 70; end
        1: begin size = CFG_W'(1); eoc_odds = 3; n = 12; end
        2: begin size = CFG_W'(0); eoc_odds = 0; n = 12; end
        3: begin size = CFG_W'(64); eoc_odds = 16; n = 80; end
        4: begin size = CFG_W'($urandom_range(2, 16)); eoc_odds = 6; end
        default: begin
          size = CFG_W'($urandom_range(0, 127));
          eoc_odds = $urandom_range(0, 20);
        end
      endcase
      src_burst = (phase == 0) || ($urandom_range(0, 3) == 0);
      snk_burst = (phase != 0) && ($urandom_range(0, 3) == 0);
      write_chunk_size(size);
      if (phase == 0) sink_hold = HOLD_CYCLES;
      for (int i = 0; i < n; i++)
        send_symbol(pick_symbol(), (eoc_odds != 0) && ($urandom_range(1, eoc_odds) == 1));
      items += n;
      phase++;
    end
    send_symbol(pick_symbol(), 1'b1);
    s_axis_tvalid_i <= 1'b0;

    while (chk.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (chk.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
